@@ hw/rtl/hci_packet_deframer_defines.svh @@
// Assertion macros for the HCI packet deframer.
// Used by hci_packet_deframer.sv; expects clk_i and rst_ni in scope.
`ifndef HCI_PACKET_DEFRAMER_DEFINES_SVH
`define HCI_PACKET_DEFRAMER_DEFINES_SVH

// Plain property, sampled on clk_i, off while reset is asserted.
`define HPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hpd: assertion failed");

// Same-cycle implication.
`define HPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpd: assertion failed");

// Next-cycle implication.
`define HPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpd: assertion failed");

`endif

@@ hw/rtl/hpd_pkg.sv @@
// Types and constants for the HCI packet deframer.
// No dependencies; imported by hci_packet_deframer.
package hpd_pkg;

  typedef enum logic [1:0] {
    PhType    = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StPacket  = 2'd0,
    StUnknown = 2'd1,
    StTooLong = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic CfgMaxPayload  = 1'b0;
  localparam logic CfgBredrEnable = 1'b1;

  localparam logic [15:0] MaxPayloadRst = 16'd1024;

  // Stream codes
  localparam logic [7:0] TypeEvent    = 8'h04;
  localparam logic [7:0] TypeAcl      = 8'h02;
  localparam logic [7:0] EvtLeMeta    = 8'h3E;
  localparam logic [7:0] EvtInqRssi   = 8'h22;
  localparam logic [7:0] EvtInqExt    = 8'h2F;
  localparam logic [7:0] SubAdvReport = 8'h02;

  // Header lengths in bytes
  localparam logic [2:0] EvtHdrLen  = 3'd2;
  localparam logic [2:0] MetaHdrLen = 3'd3;
  localparam logic [2:0] AclHdrLen  = 3'd4;

  localparam int unsigned HdrDepth = 4;

endpackage

@@ hw/rtl/hci_packet_deframer.sv @@
// HCI packet deframer: splits an H4 style byte stream into event and ACL packets.
// Depends on hpd_pkg and hci_packet_deframer_defines.svh.
//
// One byte is taken per cycle while the result buffer is empty or its final entry is
// leaving; otherwise the input is held off. The byte that completes a header loads
// 2 to 4 result transfers (1 if the payload is too long) into a four-entry result
// buffer; the input is held off until the final entry of that buffer leaves. Results
// come on m_axis with packet_byte in tdata, last_byte in tlast and kind, drop mark
// and status in tuser.
`include "hci_packet_deframer_defines.svh"

module hci_packet_deframer
  import hpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,   // chunk_end, no effect on parsing
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] packet_byte
  output logic        m_axis_tlast,   // last_byte
  output logic [3:0]  m_axis_tuser    // [0] packet_kind, [1] can_drop, [3:2] status
);

  // configuration
  logic [15:0] max_payload_q;
  logic        bredr_en_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic        kind_q, kind_d;
  logic [15:0] bl_q, bl_d;
  logic [2:0]  hlen_q, hlen_d;
  logic [15:0] skip_q, skip_d;
  logic        drop_q, drop_d;
  logic [7:0]  hdr_q [HdrDepth];
  logic [7:0]  hdr_w [HdrDepth];

  // result buffer
  logic [7:0]  ob_q [HdrDepth];
  logic        ob_kind_q, ob_drop_q, ob_last_q;
  status_e     ob_st_q;
  logic [2:0]  rem_q;
  logic [1:0]  rd_q;

  // buffer load from the parser
  logic        ld;
  logic [2:0]  ld_n;
  logic [7:0]  ld_bytes [HdrDepth];
  logic        ld_kind, ld_drop, ld_last;
  status_e     ld_st;

  logic        s_acc, m_acc;
  logic [7:0]  b;
  logic [1:0]  idx;
  logic [15:0] bl_dec;
  logic [2:0]  hlen_n;
  logic        drop_n;
  logic [15:0] plen;
  logic [7:0]  extra;

  assign b     = s_axis_tdata;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  // take a byte once the buffer is empty or its final entry leaves this cycle
  assign s_axis_tready = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
      bredr_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMaxPayload:  max_payload_q <= cfg_data_i;
        CfgBredrEnable: bredr_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign idx = 2'(hlen_q - bl_q[2:0]);

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    bl_d     = bl_q;
    hlen_d   = hlen_q;
    skip_d   = skip_q;
    drop_d   = drop_q;
    ld       = 1'b0;
    ld_n     = 3'd1;
    ld_kind  = 1'b0;
    ld_drop  = 1'b0;
    ld_last  = 1'b0;
    ld_st    = StPacket;
    bl_dec   = bl_q - 16'd1;
    hlen_n   = hlen_q;
    drop_n   = drop_q;
    plen     = 16'd0;
    extra    = 8'd0;
    for (int i = 0; i < HdrDepth; i++) begin
      hdr_w[i]    = hdr_q[i];
      ld_bytes[i] = 8'd0;
    end
    if (phase_q == PhHeader) begin
      hdr_w[idx] = b;
    end

    if (s_acc) begin
      if (skip_q != 16'd0) begin
        skip_d = skip_q - 16'd1;
      end else begin
        case (phase_q)
          PhType: begin
            drop_d = 1'b0;
            if (b == TypeEvent || b == TypeAcl) begin
              kind_d  = (b == TypeAcl);
              hlen_d  = (b == TypeAcl) ? AclHdrLen : EvtHdrLen;
              bl_d    = {13'd0, hlen_d};
              phase_d = PhHeader;
            end else begin
              ld          = 1'b1;
              ld_n        = 3'd1;
              ld_bytes[0] = b;
              ld_st       = StUnknown;
            end
          end
          PhHeader: begin
            if (!kind_q && idx == 2'd0) begin
              if (b == EvtLeMeta) begin
                hlen_n = MetaHdrLen;
                bl_dec = bl_q;      // one more header byte due
              end else if (bredr_en_q && (b == EvtInqRssi || b == EvtInqExt)) begin
                drop_n = 1'b1;
              end
            end
            hlen_d = hlen_n;
            if (bl_dec != 16'd0) begin
              bl_d   = bl_dec;
              drop_d = drop_n;
            end else begin
              if (!kind_q) begin
                if (hdr_w[0] == EvtLeMeta && hdr_w[2] == SubAdvReport) drop_n = 1'b1;
                extra = (hlen_n == MetaHdrLen) ? 8'd1 : 8'd0;
                plen  = (hdr_w[1] >= extra) ? {8'd0, hdr_w[1] - extra} : 16'd0;
              end else begin
                plen = {hdr_w[3], hdr_w[2]};
              end
              ld      = 1'b1;
              ld_kind = kind_q;
              ld_drop = kind_q ? 1'b0 : drop_n;
              if (plen > max_payload_q) begin
                ld_n        = 3'd1;
                ld_st       = StTooLong;
                skip_d      = plen;
                phase_d     = PhType;
                bl_d        = 16'd0;
                drop_d      = 1'b0;
              end else begin
                ld_n    = hlen_n;
                ld_last = (plen == 16'd0);
                for (int i = 0; i < HdrDepth; i++) ld_bytes[i] = hdr_w[i];
                drop_d  = drop_n;
                bl_d    = plen;
                phase_d = (plen == 16'd0) ? PhType : PhPayload;
              end
            end
          end
          PhPayload: begin
            bl_d        = (bl_q != 16'd0) ? bl_dec : bl_q;
            ld          = 1'b1;
            ld_n        = 3'd1;
            ld_bytes[0] = b;
            ld_kind     = kind_q;
            ld_drop     = kind_q ? 1'b0 : drop_q;
            ld_last     = (bl_d == 16'd0);
            if (bl_d == 16'd0) phase_d = PhType;
          end
          default: phase_d = PhType;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      kind_q  <= 1'b0;
      bl_q    <= 16'd0;
      hlen_q  <= 3'd0;
      skip_q  <= 16'd0;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      bl_q    <= bl_d;
      hlen_q  <= hlen_d;
      skip_q  <= skip_d;
      drop_q  <= drop_d;
    end
  end

  // header store and result payload: no reset
  always_ff @(posedge clk_i) begin
    if (s_acc && skip_q == 16'd0 && phase_q == PhHeader) begin
      hdr_q[idx] <= b;
    end
    if (ld) begin
      for (int i = 0; i < HdrDepth; i++) ob_q[i] <= ld_bytes[i];
      ob_kind_q <= ld_kind;
      ob_drop_q <= ld_drop;
      ob_last_q <= ld_last;
      ob_st_q   <= ld_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      rd_q  <= 2'd0;
    end else if (ld) begin
      rem_q <= ld_n;
      rd_q  <= 2'd0;
    end else if (m_acc) begin
      rem_q <= rem_q - 3'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tdata  = ob_q[rd_q];
  assign m_axis_tlast  = ob_last_q && (rem_q == 3'd1);
  assign m_axis_tuser  = {ob_st_q, ob_drop_q, ob_kind_q};

  // payload phase always has bytes outstanding
  `HPD_ASSERT_IMPL(a_payload_count, phase_q == PhPayload, bl_q != 16'd0)
  // a skipped byte never produces a transfer
  `HPD_ASSERT_NEXT(a_skip_silent, s_acc && skip_q != 16'd0, !m_axis_tvalid)
  // a dropped type byte carries no packet marks
  `HPD_ASSERT_IMPL(a_unknown_marks, m_axis_tvalid && ob_st_q == StUnknown,
                   !m_axis_tlast && !m_axis_tuser[0] && !m_axis_tuser[1])
  // buffer never holds more than a full header
  `HPD_ASSERT(a_rem_range, rem_q <= 3'd4)

endmodule
